/* rtl/skht_pkg.sv */
// Package for the string key hash table: sizes, status codes, helpers.
// No dependencies.
package skht_pkg;
  localparam int TableSlots   = 4096;
  localparam int VocabEntries = 2048;
  localparam int MaxKeyBytes  = 32;
  localparam int SlotW  = $clog2(TableSlots);
  localparam int EntryW = $clog2(VocabEntries);
  localparam int ByteW  = $clog2(MaxKeyBytes);
  localparam int LenW   = $clog2(MaxKeyBytes + 1);
  localparam int CountW = $clog2(VocabEntries + 1);
  localparam int KeyAddrW = EntryW + ByteW;
  localparam int SlotDataW = EntryW + 1;

  typedef enum logic [2:0] {
    ST_FOUND = 3'd0, ST_NOT_FOUND = 3'd1, ST_INSERTED = 3'd2,
    ST_VOCAB_FULL = 3'd3, ST_TABLE_FULL = 3'd4, ST_TOO_LONG = 3'd5
  } status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_pending;
    logic slot_start;
    logic slot_advance;
    logic slot_wr;
    logic cmp_start;
    logic cmp_advance;
    logic key_wr;
    logic commit;
    logic clr_rd;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic overflow;
    logic slot_used;
    logic len_match;
    logic byte_match;
    logic cmp_done;
    logic wr_done;
    logic probe_wrapped;
    logic vocab_full;
    logic table_full;
    logic clr_done;
  } stat_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h2d;
  endfunction
endpackage

/* rtl/skht_if.sv */
// Valid/ready channel interfaces for key beats and result beats.
// No dependencies.
interface skht_key_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] key_byte;
  logic       key_last;
  logic       key_empty;
  modport source (output valid, operation, key_byte, key_last, key_empty, input ready);
  modport sink (input valid, operation, key_byte, key_last, key_empty, output ready);
endinterface

interface skht_res_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [10:0] entry_index;
  logic        letters_only;
  modport source (output valid, status, entry_index, letters_only, input ready);
  modport sink (input valid, status, entry_index, letters_only, output ready);
endinterface

/* rtl/skht_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module skht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* rtl/skht_datapath.sv */
// Datapath: key gathering, hash, slot/key memories, probe and compare counters.
// Depends on skht_pkg, skht_ram.
module skht_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  beat,
  input  logic [7:0]            key_byte,
  input  logic                  key_empty,
  input  skht_pkg::ctrl_t       ctrl,
  output skht_pkg::stat_t       stat,
  output logic [skht_pkg::EntryW-1:0] hit_entry,
  output logic                  hit_letters,
  output logic [skht_pkg::EntryW-1:0] new_entry,
  output logic                  pend_letters
);
  logic [63:0] hash;
  logic [skht_pkg::LenW-1:0] plen;
  logic overflow;
  logic [7:0] pkey [skht_pkg::MaxKeyBytes];
  logic [skht_pkg::CountW-1:0] count;
  logic [skht_pkg::SlotW:0] probe_n;
  logic [skht_pkg::SlotW-1:0] slot;
  logic [skht_pkg::ByteW-1:0] cidx;
  logic [skht_pkg::LenW-1:0] ccount;
  logic [skht_pkg::SlotW-1:0] clr_addr;
  logic clr_done;
  logic [skht_pkg::SlotDataW-1:0] slot_rdata, slot_wdata;
  logic [skht_pkg::SlotW-1:0] slot_addr;
  logic [skht_pkg::EntryW-1:0] cur_entry;
  logic [7:0] key_rdata;
  logic [skht_pkg::KeyAddrW-1:0] key_addr;
  logic [skht_pkg::LenW-1:0] len_rdata;
  logic flag_rdata;
  logic [skht_pkg::EntryW-1:0] meta_addr;
  logic meta_we;
  logic [63:0] ext;

  assign ext = {{56{key_byte[7]}}, key_byte};

  // Gather key beats and update running hash
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_pending) begin
      hash <= '0;
      plen <= '0;
      overflow <= 1'b0;
      pend_letters <= 1'b1;
    end else if (beat && !key_empty) begin
      hash <= (hash << 8) + hash + ext;
      if (!skht_pkg::is_letter(key_byte)) pend_letters <= 1'b0;
      if (plen < skht_pkg::LenW'(skht_pkg::MaxKeyBytes)) begin
        pkey[plen[skht_pkg::ByteW-1:0]] <= key_byte;
        plen <= plen + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // Probe position and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      clr_addr <= '0;
      clr_done <= 1'b0;
    end else begin
      if (ctrl.clr_rd && !clr_done) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) clr_done <= 1'b1;
      end
      if (ctrl.commit) count <= count + 1'b1;
    end
    if (ctrl.slot_start) begin
      slot <= hash[skht_pkg::SlotW-1:0];
      probe_n <= '0;
    end else if (ctrl.slot_advance) begin
      slot <= slot + 1'b1;
      probe_n <= probe_n + 1'b1;
    end
    if (ctrl.cmp_start) begin
      cidx <= '0;
      ccount <= '0;
    end else if (ctrl.cmp_advance) begin
      cidx <= cidx + 1'b1;
      ccount <= ccount + 1'b1;
    end
  end

  assign slot_addr = ctrl.clr_rd ? clr_addr : slot;
  assign slot_wdata = ctrl.clr_rd ? '0 : {1'b1, new_entry};
  assign cur_entry = slot_rdata[skht_pkg::EntryW-1:0];
  assign new_entry = count[skht_pkg::EntryW-1:0];

  skht_ram #(.Width(skht_pkg::SlotDataW), .Depth(skht_pkg::TableSlots)) u_slots (
    .clk, .we(ctrl.slot_wr || (ctrl.clr_rd && !clr_done)), .addr(slot_addr),
    .wdata(slot_wdata), .rdata(slot_rdata));

  // Key store: write during insert copy, read during compare
  assign key_addr = ctrl.key_wr ? {new_entry, cidx} : {cur_entry, cidx};
  skht_ram #(.Width(8), .Depth(skht_pkg::VocabEntries * skht_pkg::MaxKeyBytes)) u_keys (
    .clk, .we(ctrl.key_wr), .addr(key_addr), .wdata(pkey[cidx]), .rdata(key_rdata));

  assign meta_we = ctrl.commit;
  assign meta_addr = meta_we ? new_entry : cur_entry;
  skht_ram #(.Width(skht_pkg::LenW), .Depth(skht_pkg::VocabEntries)) u_lens (
    .clk, .we(meta_we), .addr(meta_addr), .wdata(plen), .rdata(len_rdata));
  skht_ram #(.Width(1), .Depth(skht_pkg::VocabEntries)) u_flags (
    .clk, .we(meta_we), .addr(meta_addr), .wdata(pend_letters), .rdata(flag_rdata));

  // Compare pointer is registered to line up with the registered key read; byte_match checks the previous index
  logic [skht_pkg::ByteW-1:0] cidx_q;
  always_ff @(posedge clk) cidx_q <= cidx;

  assign hit_entry = cur_entry;
  assign hit_letters = flag_rdata;
  assign stat.overflow = overflow;
  assign stat.slot_used = slot_rdata[skht_pkg::EntryW];
  assign stat.len_match = (len_rdata == plen);
  assign stat.byte_match = (key_rdata == pkey[cidx_q]);
  assign stat.cmp_done = (ccount >= plen);
  assign stat.wr_done = (ccount >= plen);
  assign stat.probe_wrapped = (probe_n >= (skht_pkg::SlotW+1)'(skht_pkg::TableSlots - 1));
  assign stat.vocab_full = (count >= skht_pkg::CountW'(skht_pkg::VocabEntries));
  assign stat.table_full = ({1'b0, count} >= (skht_pkg::CountW+1)'(skht_pkg::TableSlots));
  assign stat.clr_done = clr_done;
endmodule

/* rtl/skht_ctrl.sv */
// Controller: sequences clear, probe, compare and insert; owns result register.
// Depends on skht_pkg.
module skht_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic                  in_op,
  output logic                  in_ready,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [2:0]            res_status,
  output logic [10:0]           res_index,
  output logic                  res_letters,
  output skht_pkg::ctrl_t       ctrl,
  input  skht_pkg::stat_t       stat,
  input  logic [skht_pkg::EntryW-1:0] hit_entry,
  input  logic                  hit_letters,
  input  logic [skht_pkg::EntryW-1:0] new_entry,
  input  logic                  pend_letters
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SRD, S_SCHK, S_LCHK, S_CCHK,
    S_IRD, S_ICHK, S_ICOPY, S_DONE
  } state_t;
  state_t state;
  logic op;

  assign in_ready = (state == S_IDLE) && !res_valid;

  always_comb begin
    ctrl = '0;
    unique case (state)
      S_CLEAR:    ctrl.clr_rd = 1'b1;
      S_IDLE:     ;
      S_DISPATCH: ctrl.slot_start = 1'b1;
      S_SRD:      ;
      S_SCHK:     ctrl.cmp_start = 1'b1;
      S_LCHK:     ctrl.cmp_advance = 1'b1;
      S_CCHK:     ctrl.cmp_advance = 1'b1;
      S_IRD:      ;
      S_ICHK:     ctrl.cmp_start = !stat.slot_used;
      S_ICOPY:    ctrl.key_wr = !stat.wr_done;
      S_DONE:     ;
      default:    ;
    endcase
    if (state == S_ICOPY) ctrl.cmp_advance = !stat.wr_done;
    if (state == S_ICOPY && stat.wr_done) begin
      ctrl.slot_wr = 1'b1;
      ctrl.commit = 1'b1;
    end
    if (state == S_ICHK && stat.slot_used) ctrl.slot_advance = 1'b1;
    if (state == S_CCHK && !stat.byte_match) ctrl.slot_advance = 1'b1;
    if (state == S_LCHK && !stat.len_match) ctrl.slot_advance = 1'b1;
    if (state == S_DONE) ctrl.clear_pending = 1'b1;
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR: if (stat.clr_done) state <= S_IDLE;
        S_IDLE: if (in_valid && in_ready && in_last) begin
          op <= in_op;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          res_index <= '0;
          res_letters <= 1'b0;
          if (stat.overflow) begin
            res_status <= skht_pkg::ST_TOO_LONG;
            state <= S_DONE;
          end else if (!op) begin
            state <= S_SRD;
          end else if (stat.vocab_full) begin
            res_status <= skht_pkg::ST_VOCAB_FULL;
            state <= S_DONE;
          end else if (stat.table_full) begin
            res_status <= skht_pkg::ST_TABLE_FULL;
            state <= S_DONE;
          end else begin
            state <= S_IRD;
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: if (!stat.slot_used) begin
          res_status <= skht_pkg::ST_NOT_FOUND;
          state <= S_DONE;
        end else begin
          state <= S_LCHK;
        end
        // Length check; byte 0 read is issued here, an empty key hits at once
        S_LCHK: begin
          if (!stat.len_match) begin
            if (stat.probe_wrapped) begin
              res_status <= skht_pkg::ST_NOT_FOUND;
              state <= S_DONE;
            end else begin
              state <= S_SRD;
            end
          end else if (stat.cmp_done) begin
            res_status <= skht_pkg::ST_FOUND;
            res_index <= 11'(hit_entry);
            res_letters <= hit_letters;
            state <= S_DONE;
          end else begin
            state <= S_CCHK;
          end
        end
        // Check one key byte per cycle while the next read is in flight
        S_CCHK: begin
          if (!stat.byte_match) begin
            if (stat.probe_wrapped) begin
              res_status <= skht_pkg::ST_NOT_FOUND;
              state <= S_DONE;
            end else begin
              state <= S_SRD;
            end
          end else if (stat.cmp_done) begin
            res_status <= skht_pkg::ST_FOUND;
            res_index <= 11'(hit_entry);
            res_letters <= hit_letters;
            state <= S_DONE;
          end else begin
            state <= S_CCHK;
          end
        end
        S_IRD: state <= S_ICHK;
        S_ICHK: state <= stat.slot_used ? S_IRD : S_ICOPY;
        S_ICOPY: if (stat.wr_done) begin
          res_status <= skht_pkg::ST_INSERTED;
          res_index <= 11'(new_entry);
          res_letters <= pend_letters;
          state <= S_DONE;
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/string_key_hash_table.sv */
// Top level of the string key hash table: controller plus datapath.
// Depends on skht_pkg, skht_if, skht_ctrl, skht_datapath.
//
//  channel  dir  beat carries
//  key      in   operation, key_byte, key_last, key_empty
//  res      out  status, entry_index, letters_only
//
// Key beats are taken only while the controller is idle. A final beat moves to
// dispatch; a search then reads and checks each probed slot, compares the length
// and then the key bytes, an insert reads and checks each probed slot, copies
// the key bytes and commits. Rejected keys skip the walk. The result is then
// posted and blocks input until taken. After reset a clearing pass runs over all
// 4096 entries of the slot memory before the first beat is taken.
module string_key_hash_table (
  input logic clk,
  input logic rst,
  skht_key_if.sink key,
  skht_res_if.source res
);
  skht_pkg::ctrl_t ctrl;
  skht_pkg::stat_t stat;
  logic [skht_pkg::EntryW-1:0] hit_entry, new_entry;
  logic hit_letters, pend_letters;

  skht_ctrl u_ctrl (
    .clk, .rst, .in_valid(key.valid), .in_last(key.key_last), .in_op(key.operation),
    .in_ready(key.ready), .res_valid(res.valid), .res_ready(res.ready),
    .res_status(res.status), .res_index(res.entry_index), .res_letters(res.letters_only),
    .ctrl, .stat, .hit_entry, .hit_letters, .new_entry, .pend_letters);

  skht_datapath u_dp (
    .clk, .rst, .beat(key.valid && key.ready), .key_byte(key.key_byte),
    .key_empty(key.key_empty), .ctrl, .stat, .hit_entry, .hit_letters,
    .new_entry, .pend_letters);
endmodule

/* rtl/skht_checker.sv */
// Port-level assertions for string_key_hash_table, attached by bind.
// Depends on string_key_hash_table.
module skht_props (
  input logic clk, input logic rst,
  input logic key_valid, input logic key_ready, input logic key_last,
  input logic res_valid, input logic res_ready, input logic [2:0] res_status
);
  // No new key beat while a result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !key_ready) else $error("input taken with result pending");
  // Result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status))
    else $error("result dropped");
  // Status code stays in range
  a_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status <= 3'd5) else $error("bad status");
  // Final beat stalls input next cycle
  a_stall: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready && key_last |=> !key_ready) else $error("no stall");
endmodule

bind string_key_hash_table skht_props u_chk (
  .clk, .rst, .key_valid(key.valid), .key_ready(key.ready), .key_last(key.key_last),
  .res_valid(res.valid), .res_ready(res.ready), .res_status(res.status));

/* verif/skht_checker.sv */
// Checker for the string key hash table: watches key and result beats,
// predicts each result and compares it. Depends on skht_pkg and skht_if.
`timescale 1ns / 100ps

module skht_checker (
  input  logic clk,
  input  logic rst,
  skht_key_if  key,
  skht_res_if  res,
  output int   fail_count,
  output int   waiting
);

  typedef struct packed {
    skht_pkg::status_t               status;
    logic [skht_pkg::EntryW-1:0]     index;
    logic                            letters;
  } outcome_t;

  outcome_t lookup_q[$];

  // Predicted table contents
  logic              slot_used  [skht_pkg::TableSlots];
  logic [skht_pkg::EntryW-1:0] slot_entry [skht_pkg::TableSlots];
  logic [7:0]        word_bytes [skht_pkg::VocabEntries][skht_pkg::MaxKeyBytes];
  int                word_len   [skht_pkg::VocabEntries];
  logic              word_alpha [skht_pkg::VocabEntries];
  int                entry_total;

  // Key being gathered
  logic [7:0]  cur_bytes [skht_pkg::MaxKeyBytes];
  int          cur_len;
  logic        cur_long;
  logic [63:0] cur_hash;
  logic        cur_alpha;

  function automatic logic alpha_byte(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "-";
  endfunction

  function automatic logic same_word(input int e);
    if (word_len[e] != cur_len) return 1'b0;
    for (int i = 0; i < cur_len; i++)
      if (word_bytes[e][i] != cur_bytes[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void restart_key();
    cur_len   = 0;
    cur_long  = 1'b0;
    cur_hash  = '0;
    cur_alpha = 1'b1;
  endfunction

  // Fold one beat into the pending key; on the last beat predict the lookup
  function automatic void take_beat(input logic op, input logic [7:0] b,
                                    input logic last, input logic empty);
    outcome_t o;
    int slot;
    if (!empty) begin
      cur_hash = cur_hash * 64'd257 + {{56{b[7]}}, b};
      if (!alpha_byte(b)) cur_alpha = 1'b0;
      if (cur_len < skht_pkg::MaxKeyBytes) begin
        cur_bytes[cur_len] = b;
        cur_len++;
      end else begin
        cur_long = 1'b1;
      end
    end
    if (!last) return;
    o = '{status: skht_pkg::ST_NOT_FOUND, index: '0, letters: 1'b0};
    slot = int'(cur_hash % 64'(skht_pkg::TableSlots));
    if (cur_long) begin
      o.status = skht_pkg::ST_TOO_LONG;
    end else if (!op) begin
      for (int n = 0; n < skht_pkg::TableSlots; n++) begin
        if (!slot_used[slot]) break;
        if (same_word(int'(slot_entry[slot]))) begin
          o.status  = skht_pkg::ST_FOUND;
          o.index   = slot_entry[slot];
          o.letters = word_alpha[slot_entry[slot]];
          break;
        end
        slot = (slot + 1) % skht_pkg::TableSlots;
      end
    end else if (entry_total >= skht_pkg::VocabEntries) begin
      o.status = skht_pkg::ST_VOCAB_FULL;
    end else if (entry_total >= skht_pkg::TableSlots) begin
      o.status = skht_pkg::ST_TABLE_FULL;
    end else begin
      while (slot_used[slot]) slot = (slot + 1) % skht_pkg::TableSlots;
      for (int i = 0; i < cur_len; i++) word_bytes[entry_total][i] = cur_bytes[i];
      word_len[entry_total]   = cur_len;
      word_alpha[entry_total] = cur_alpha;
      slot_used[slot]  = 1'b1;
      slot_entry[slot] = skht_pkg::EntryW'(entry_total);
      o.status  = skht_pkg::ST_INSERTED;
      o.index   = skht_pkg::EntryW'(entry_total);
      o.letters = cur_alpha;
      entry_total++;
    end
    lookup_q.push_back(o);
    restart_key();
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int s = 0; s < skht_pkg::TableSlots; s++) slot_used[s] = 1'b0;
      entry_total = 0;
      restart_key();
      lookup_q.delete();
      fail_count = 0;
    end else begin
      if (key.valid && key.ready)
        take_beat(key.operation, key.key_byte, key.key_last, key.key_empty);
      // Compare each result beat with the oldest prediction
      if (res.valid && res.ready) begin
        if (lookup_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result status=%0d index=%0d letters=%0b",
                     $realtime, res.status, res.entry_index, res.letters_only);
        end else begin
          want = lookup_q.pop_front();
          if (res.status != want.status || res.entry_index != want.index ||
              res.letters_only != want.letters) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected status=%0d index=%0d letters=%0b, got %0d %0d %0b",
                       $realtime, want.status, want.index, want.letters,
                       res.status, res.entry_index, res.letters_only);
          end
        end
      end
    end
    waiting = lookup_q.size();
  end

endmodule

/* verif/testbench.sv */
// Testbench top for the string key hash table: clock, reset, key stimulus,
// result back-pressure and verdict. Depends on skht_pkg, skht_if, skht_checker.
`timescale 1ns / 100ps

module testbench;

  localparam int RunLimit = 3000000;
  localparam int HoldCycles = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   waiting;
  int   cycles = 0;
  int   beats = 0;
  int   entries = 0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;

  // Key under construction and keys known to be stored
  logic [7:0] kbuf [40];
  logic [7:0] pool_key [skht_pkg::VocabEntries][skht_pkg::MaxKeyBytes];
  int         pool_len [skht_pkg::VocabEntries];
  int         pool_n = 0;

  skht_key_if key (.clk(clk));
  skht_res_if res (.clk(clk));

  string_key_hash_table uut (.clk(clk), .rst(rst), .key(key), .res(res));

  skht_checker chk (
    .clk(clk), .rst(rst), .key(key), .res(res),
    .fail_count(fail_count), .waiting(waiting)
  );

  always #4 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive result ready: random stalls, quiet stretches, one long hold-off
  initial res.ready = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      res.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      res.ready <= 1'b0;
      hold_cnt <= HoldCycles;
      hold_req <= 1'b0;
    end else begin
      res.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0: return 8'($urandom_range("z", "a"));
      1: return 8'($urandom_range("Z", "A"));
      2: return "-";
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void fill_key(input int len);
    for (int i = 0; i < len; i++) kbuf[i] = pick_byte();
  endfunction

  // Send one beat, starting and ending at a falling edge
  task automatic send_beat(input logic op, input logic [7:0] b,
                           input logic last, input logic empty);
    while (!quiet && $urandom_range(99) < 24) begin
      key.valid <= 1'b0;
      @(negedge clk);
    end
    key.valid     <= 1'b1;
    key.operation <= op;
    key.key_byte  <= b;
    key.key_last  <= last;
    key.key_empty <= empty;
    @(posedge clk);
    while (!key.ready) @(posedge clk);
    @(negedge clk);
    if (!(empty && !last)) beats++;
  endtask

  // Send kbuf[0..len-1]; end with an empty last beat when asked or len is 0
  task automatic send_key(input logic op, input int len, input logic empty_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_beat(1'($urandom), 8'($urandom), 1'b0, 1'b1);
      send_beat((i == len - 1 && !empty_end) ? op : 1'($urandom), kbuf[i],
                i == len - 1 && !empty_end, 1'b0);
    end
    if (empty_end || len == 0) send_beat(op, 8'($urandom), 1'b1, 1'b1);
    if (op && len <= skht_pkg::MaxKeyBytes && entries < skht_pkg::VocabEntries) begin
      entries++;
      if (pool_n < skht_pkg::VocabEntries) begin
        for (int i = 0; i < len; i++) pool_key[pool_n][i] = kbuf[i];
        pool_len[pool_n] = len;
        pool_n++;
      end
    end
  endtask

  task automatic load_pool(input int p);
    for (int i = 0; i < pool_len[p]; i++) kbuf[i] = pool_key[p][i];
  endtask

  task automatic drain();
    while (waiting != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    int len;
    key.valid     = 1'b0;
    key.operation = 1'b0;
    key.key_byte  = '0;
    key.key_last  = 1'b0;
    key.key_empty = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty key, byte extremes, longest and overlong keys,
    // duplicates, misses and an empty final beat after bytes
    send_key(1'b0, 0, 1'b1);
    send_key(1'b1, 0, 1'b1);
    send_key(1'b0, 0, 1'b0);
    foreach (kbuf[i]) kbuf[i] = 8'hff;
    send_key(1'b1, 1, 1'b0);
    kbuf[0] = 8'h00; send_key(1'b1, 1, 1'b0);
    kbuf[0] = 8'h80; send_key(1'b1, 1, 1'b0);
    kbuf[0] = 8'h7f; send_key(1'b1, 1, 1'b0);
    kbuf[0] = "z"; kbuf[1] = "A"; kbuf[2] = "-";
    send_key(1'b1, 3, 1'b0);
    send_key(1'b1, 3, 1'b1);
    send_key(1'b0, 3, 1'b0);
    foreach (kbuf[i]) kbuf[i] = 8'hff;
    send_key(1'b1, skht_pkg::MaxKeyBytes, 1'b0);
    send_key(1'b0, skht_pkg::MaxKeyBytes, 1'b0);
    send_key(1'b1, skht_pkg::MaxKeyBytes + 1, 1'b0);
    send_key(1'b0, 40, 1'b1);
    kbuf[0] = 8'h00; send_key(1'b0, 1, 1'b0);
    kbuf[0] = 8'h55; kbuf[1] = 8'haa; send_key(1'b0, 2, 1'b0);

    // Random mix: inserts, hits, misses, overlong keys
    while (beats < 1800) begin
      if (beats > 300 && beats < 500) quiet = 1'b1;
      else quiet = 1'b0;
      if (beats >= 900 && beats < 905) hold_req = 1'b1;
      if (beats >= 1200 && beats < 1205) drain();
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(skht_pkg::MaxKeyBytes)
                                     : $urandom_range(8, 1);
      if (pick < 45) begin
        fill_key(len);
        send_key(1'b1, len, $urandom_range(7) == 0);
      end else if (pick < 85 && pool_n > 0) begin
        pick = $urandom_range(pool_n - 1);
        load_pool(pick);
        send_key(1'b0, pool_len[pick], $urandom_range(7) == 0);
      end else if (pick < 95) begin
        fill_key(len);
        send_key(1'b0, len, 1'b0);
      end else begin
        len = $urandom_range(39, skht_pkg::MaxKeyBytes + 1);
        fill_key(len);
        send_key(1'($urandom), len, 1'b0);
      end
    end
    quiet = 1'b0;

    key.valid <= 1'b0;
    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
